[rtl/lpfp_pkg.sv]
package lpfp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CFG_IDX_W = 8;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN       = 8'd1;

  localparam logic [BYTE_W-1:0] EXPECTED_VERSION_RESET = 8'd1;
  localparam logic              BIG_ENDIAN_RESET       = 1'b1;

  // Header byte positions: id in 0..7, version at 8, length in 9..16.
  localparam logic [COUNT_W-1:0] HDR_VERSION_POS = 5'd8;
  localparam logic [COUNT_W-1:0] HDR_LENGTH_POS  = 5'd9;
  localparam logic [COUNT_W-1:0] HDR_LAST_POS    = 5'd16;

  typedef struct packed {
    logic [BYTE_W-1:0] expected_version;
    logic              big_endian;
  } cfg_t;

  typedef struct packed {
    logic              has_byte;
    logic [BYTE_W-1:0] data_byte;
    logic [WORD_W-1:0] frame_id;
    logic [BYTE_W-1:0] frame_version;
    logic [WORD_W-1:0] frame_length;
    logic              frame_status;
    logic              last_of_frame;
  } result_t;

endpackage

[rtl/lpfp_if.sv]
interface lpfp_byte_if;
  logic                        valid;
  logic                        ready;
  logic [lpfp_pkg::BYTE_W-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface lpfp_result_if;
  logic                        valid;
  logic                        ready;
  logic                        has_byte;
  logic [lpfp_pkg::BYTE_W-1:0] data_byte;
  logic [lpfp_pkg::WORD_W-1:0] frame_id;
  logic [lpfp_pkg::BYTE_W-1:0] frame_version;
  logic [lpfp_pkg::WORD_W-1:0] frame_length;
  logic                        frame_status;
  logic                        last_of_frame;

  modport source (output valid, output has_byte, output data_byte, output frame_id,
                  output frame_version, output frame_length, output frame_status,
                  output last_of_frame, input ready);
  modport sink (input valid, input has_byte, input data_byte, input frame_id,
                input frame_version, input frame_length, input frame_status,
                input last_of_frame, output ready);
endinterface

interface lpfp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lpfp_pkg::CFG_IDX_W-1:0] index;
  logic [lpfp_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/lpfp_parser.sv]
module lpfp_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [lpfp_pkg::BYTE_W-1:0]   stream_byte,
  input  lpfp_pkg::cfg_t                cfg,
  output logic                          push_valid,
  output lpfp_pkg::result_t             push_data
);

  logic [lpfp_pkg::COUNT_W-1:0] header_count, header_count_next;
  logic [lpfp_pkg::WORD_W-1:0]  id_reg, id_reg_next;
  logic [lpfp_pkg::BYTE_W-1:0]  version_reg, version_reg_next;
  logic [lpfp_pkg::WORD_W-1:0]  length_reg, length_reg_next;
  logic [lpfp_pkg::WORD_W-1:0]  remaining_bytes, remaining_bytes_next;
  logic                         in_payload, in_payload_next;
  logic [lpfp_pkg::COUNT_W-1:0] len_pos;
  logic                         last_payload;

  // Big-endian fields shift in from the bottom; little-endian ones land by position.
  function automatic logic [lpfp_pkg::WORD_W-1:0] put_byte(
    input logic [lpfp_pkg::WORD_W-1:0] acc,
    input logic [2:0]                  pos,
    input logic [lpfp_pkg::BYTE_W-1:0] b,
    input logic                        be
  );
    logic [lpfp_pkg::WORD_W-1:0] res;
    res = acc;
    if (be) begin
      res = {acc[lpfp_pkg::WORD_W-lpfp_pkg::BYTE_W-1:0], b};
    end else begin
      res[pos*lpfp_pkg::BYTE_W +: lpfp_pkg::BYTE_W] = b;
    end
    return res;
  endfunction

  assign len_pos      = header_count - lpfp_pkg::HDR_LENGTH_POS;
  assign last_payload = (remaining_bytes == lpfp_pkg::WORD_W'(1));

  always_comb begin
    header_count_next    = header_count;
    id_reg_next          = id_reg;
    version_reg_next     = version_reg;
    length_reg_next      = length_reg;
    remaining_bytes_next = remaining_bytes;
    in_payload_next      = in_payload;
    push_valid           = 1'b0;
    push_data.has_byte   = 1'b0;
    push_data.data_byte  = '0;
    push_data.last_of_frame = 1'b0;
    if (fire) begin
      if (in_payload) begin
        remaining_bytes_next    = remaining_bytes - lpfp_pkg::WORD_W'(1);
        push_valid              = 1'b1;
        push_data.has_byte      = 1'b1;
        push_data.data_byte     = stream_byte;
        push_data.last_of_frame = last_payload;
        if (last_payload) begin
          in_payload_next   = 1'b0;
          header_count_next = '0;
        end
      end else begin
        if (header_count < lpfp_pkg::HDR_VERSION_POS) begin
          id_reg_next = put_byte(id_reg, header_count[2:0], stream_byte, cfg.big_endian);
        end else if (header_count == lpfp_pkg::HDR_VERSION_POS) begin
          version_reg_next = stream_byte;
        end else begin
          length_reg_next = put_byte(length_reg, len_pos[2:0], stream_byte, cfg.big_endian);
        end
        if (header_count != lpfp_pkg::HDR_LAST_POS) begin
          header_count_next = header_count + lpfp_pkg::COUNT_W'(1);
        end else begin
          header_count_next = '0;
          if (length_reg_next == '0) begin
            // An empty frame still reports its header once.
            push_valid              = 1'b1;
            push_data.last_of_frame = 1'b1;
          end else begin
            remaining_bytes_next = length_reg_next;
            in_payload_next      = 1'b1;
          end
        end
      end
    end
    push_data.frame_id      = id_reg_next;
    push_data.frame_version = version_reg_next;
    push_data.frame_length  = length_reg_next;
    push_data.frame_status  = (version_reg_next != cfg.expected_version);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count    <= '0;
      id_reg          <= '0;
      version_reg     <= '0;
      length_reg      <= '0;
      remaining_bytes <= '0;
      in_payload      <= 1'b0;
    end else begin
      header_count    <= header_count_next;
      id_reg          <= id_reg_next;
      version_reg     <= version_reg_next;
      length_reg      <= length_reg_next;
      remaining_bytes <= remaining_bytes_next;
      in_payload      <= in_payload_next;
    end
  end

endmodule

[rtl/lpfp_skid.sv]
module lpfp_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  lpfp_pkg::result_t push_data,
  output logic              space,
  lpfp_result_if.source     result
);

  logic              out_valid;
  lpfp_pkg::result_t out_data;
  logic              skid_valid;
  lpfp_pkg::result_t skid_data;
  logic              take;

  assign take  = out_valid && result.ready;
  // Pushes only arrive while the skid entry is empty, so nothing is ever dropped.
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !take) begin
      if (push_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !take) begin
      if (push_valid) begin
        skid_data <= push_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (push_valid) begin
      out_data <= push_data;
    end
  end

  assign result.valid         = out_valid;
  assign result.has_byte      = out_data.has_byte;
  assign result.data_byte     = out_data.data_byte;
  assign result.frame_id      = out_data.frame_id;
  assign result.frame_version = out_data.frame_version;
  assign result.frame_length  = out_data.frame_length;
  assign result.frame_status  = out_data.frame_status;
  assign result.last_of_frame = out_data.last_of_frame;

endmodule

[rtl/length_prefixed_frame_parser.sv]
// Frame parser for a byte stream of 17-byte headers (64-bit id, 8-bit version, 64-bit
// length) each followed by its payload. One byte is taken per clock cycle for as long as
// the result side keeps taking results; each result is registered before it appears.
// Header bytes give no result, except that the last header byte of an empty
// frame gives a single result without a data byte. The result side is a two-entry buffer:
// after the result side stalls, one more result can be produced before the input stalls
// too, and header bytes keep being taken until that second entry is filled.
// Configuration writes are always taken and are meant for when the block is idle.
module length_prefixed_frame_parser (
  input logic           clk,
  input logic           rst,
  lpfp_byte_if.sink     stream,
  lpfp_result_if.source result,
  lpfp_cfg_if.sink      cfg
);

  lpfp_pkg::cfg_t    cfg_regs;
  logic              fire;
  logic              space;
  logic              push_valid;
  lpfp_pkg::result_t push_data;

  assign cfg.ready    = 1'b1;
  assign stream.ready = space;
  assign fire         = stream.valid && space;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.expected_version <= lpfp_pkg::EXPECTED_VERSION_RESET;
      cfg_regs.big_endian       <= lpfp_pkg::BIG_ENDIAN_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        lpfp_pkg::CFG_EXPECTED_VERSION: begin
          cfg_regs.expected_version <= cfg.data;
        end
        lpfp_pkg::CFG_BIG_ENDIAN: begin
          cfg_regs.big_endian <= cfg.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  lpfp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .stream_byte (stream.stream_byte),
    .cfg         (cfg_regs),
    .push_valid  (push_valid),
    .push_data   (push_data)
  );

  lpfp_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .space      (space),
    .result     (result)
  );

  // The input only stalls while results are held back.
  assert property (@(posedge clk) disable iff (rst) !stream.ready |-> result.valid)
    else $error("input stalled with no result pending");

  // A result only comes from a byte taken in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
                   push_valid |-> (stream.valid && stream.ready))
    else $error("result produced without an accepted byte");

  // A result without a data byte belongs to an empty frame and closes it.
  assert property (@(posedge clk) disable iff (rst)
                   (result.valid && !result.has_byte) |->
                   (result.last_of_frame && result.frame_length == '0 &&
                    result.data_byte == '0))
    else $error("bad empty-frame result");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

endmodule
